// File: rtl/tks_pkg.sv
// Shared constants, register codes and control structs for the top-k score selector.
// No dependencies; every other file imports this package.
package tks_pkg;

	localparam int MAX_TOP_K   = 16;
	localparam int MAX_CLASSES = 4096;

	localparam int SCORE_W    = 32;
	localparam int CODE_W     = 8;
	localparam int KEEP_W     = 5;
	localparam int CLASS_W    = 12;
	localparam int RANK_W     = 4;
	localparam int FILL_W     = $clog2(MAX_TOP_K + 1);
	localparam int SLOT_W     = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
	localparam int CNT_W      = $clog2(MAX_CLASSES + 1);
	localparam int PROD_W     = SCORE_W + 1 + CODE_W + 1;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_KEEP_COUNT   = 2'd0,
		REG_SCORE_FORMAT = 2'd1,
		REG_QUANT_SCALE  = 2'd2,
		REG_QUANT_ZERO   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [KEEP_W-1:0]  keep_count;
		logic               score_format;
		logic [SCORE_W-1:0] quant_scale;
		logic [CODE_W-1:0]  quant_zero_point;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic insert;
		logic emit_adv;
		logic clear_run;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic emit_empty;
		logic emit_last;
	} dp_status_t;

endpackage

// File: rtl/tks_if.sv
// Valid/ready channel interfaces for score transactions in and result transactions out.
// Depends on tks_pkg.
interface tks_score_if import tks_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score_value;
	logic                      last_element;

	modport source(output valid, score_value, last_element, input ready);
	modport sink(input valid, score_value, last_element, output ready);
endinterface

interface tks_result_if import tks_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CLASS_W-1:0]        class_index;
	logic signed [SCORE_W-1:0] confidence;
	logic [RANK_W-1:0]         rank;
	logic                      last_result;
	logic                      count_overflow;

	modport source(output valid, class_index, confidence, rank, last_result, count_overflow,
		input ready);
	modport sink(input valid, class_index, confidence, rank, last_result, count_overflow,
		output ready);
endinterface

// File: rtl/top_k_score_selector.sv
// Top level of the streaming top-k score selector: controller, datapath and APB registers.
// Depends on tks_pkg, tks_if, tks_cfg, tks_ctrl and tks_datapath.
//
//   channel   dir  handshake             payload
//   scores    in   valid/ready           score_value, last_element
//   results   out  valid/ready           class_index, confidence, rank, last_result,
//                                        count_overflow
//   apb       in   psel/penable/pready   keep_count @0x0, score_format @0x4,
//                                        quant_scale @0x8, quant_zero_point @0xC
//
// Each score transaction is captured together with the dequantizing multiply,
// then inserted into the sorted list across all list slots in parallel.
// A transaction marked last is followed by one result per kept entry, one per cycle
// while results.ready is high; results.ready low holds the current result.
// With no kept entries the last element passes through the emit state and gives no results.
// Reset clears the run state at once; no clearing pass is needed.
module top_k_score_selector import tks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tks_score_if.sink             scores,
	tks_result_if.source          results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	tks_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scores.valid),
		.in_ready  (scores.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	tks_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.score_value    (scores.score_value),
		.last_element   (scores.last_element),
		.class_index    (results.class_index),
		.confidence     (results.confidence),
		.rank           (results.rank),
		.last_result    (results.last_result),
		.count_overflow (results.count_overflow)
	);

endmodule

// File: rtl/tks_cfg.sv
// APB configuration registers of the top-k score selector.
// Depends on tks_pkg.
module tks_cfg import tks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.keep_count       <= KEEP_W'(1);
			cfg_q.score_format     <= 1'b0;
			cfg_q.quant_scale      <= SCORE_W'(65536);
			cfg_q.quant_zero_point <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KEEP_COUNT:   cfg_q.keep_count       <= pwdata[KEEP_W-1:0];
				REG_SCORE_FORMAT: cfg_q.score_format     <= pwdata[0];
				REG_QUANT_SCALE:  cfg_q.quant_scale      <= pwdata[SCORE_W-1:0];
				REG_QUANT_ZERO:   cfg_q.quant_zero_point <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KEEP_COUNT:   prdata = APB_DATA_W'(cfg_q.keep_count);
			REG_SCORE_FORMAT: prdata = APB_DATA_W'(cfg_q.score_format);
			REG_QUANT_SCALE:  prdata = APB_DATA_W'(cfg_q.quant_scale);
			REG_QUANT_ZERO:   prdata = APB_DATA_W'(cfg_q.quant_zero_point);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/tks_ctrl.sv
// Controller of the top-k score selector: sequences capture, insertion and result emission.
// Depends on tks_pkg; drives commands into tks_datapath.
module tks_ctrl import tks_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT) && !status.emit_empty;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_INSERT: cmd.insert = 1'b1;
			ST_EMIT: begin
				if (status.emit_empty) begin
					cmd.clear_run = 1'b1;
				end else if (out_ready) begin
					cmd.clear_run = status.emit_last;
					cmd.emit_adv  = !status.emit_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_INSERT;
				end
				ST_INSERT: state_q <= status.last ? ST_EMIT : ST_IDLE;
				ST_EMIT: begin
					if (cmd.clear_run) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/tks_datapath.sv
// Datapath of the top-k score selector: dequantizer, sorted score list and result readout.
// Depends on tks_pkg; commanded by tks_ctrl.
module tks_datapath import tks_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  logic signed [SCORE_W-1:0] score_value,
	input  logic                      last_element,
	output logic [CLASS_W-1:0]        class_index,
	output logic signed [SCORE_W-1:0] confidence,
	output logic [RANK_W-1:0]         rank,
	output logic                      last_result,
	output logic                      count_overflow
);

	logic signed [SCORE_W-1:0] raw_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      last_s1;

	logic signed [SCORE_W-1:0] best_score_q [MAX_TOP_K];
	logic [CLASS_W-1:0]        best_idx_q   [MAX_TOP_K];
	logic [FILL_W-1:0]         filled_q;
	logic [CNT_W-1:0]          elem_cnt_q;
	logic                      ovf_q;
	logic [SLOT_W-1:0]         ptr_q;

	logic signed [CODE_W:0]    code_diff;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [SCORE_W-1:0] sat_score;
	logic signed [SCORE_W-1:0] new_score;
	logic [FILL_W-1:0]         k_lim;
	logic [FILL_W-1:0]         fill_eff;
	logic [MAX_TOP_K-1:0]      ge;
	logic [MAX_TOP_K-1:0]      lane_wr;
	logic [MAX_TOP_K-1:0]      lane_new;
	logic                      ge_last_slot;
	logic                      insert_ok;
	logic                      in_range;

	assign code_diff = signed'({1'b0, score_value[CODE_W-1:0]})
		- signed'({1'b0, cfg.quant_zero_point});
	assign prod_c    = signed'({1'b0, cfg.quant_scale}) * code_diff;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_s1  <= score_value;
			prod_s1 <= prod_c;
			last_s1 <= last_element;
		end
	end

	always_comb begin
		if (&prod_s1[PROD_W-1:SCORE_W-1] || ~|prod_s1[PROD_W-1:SCORE_W-1]) begin
			sat_score = prod_s1[SCORE_W-1:0];
		end else begin
			sat_score = prod_s1[PROD_W-1] ? SCORE_MIN : SCORE_MAX;
		end
		new_score = cfg.score_format ? sat_score : raw_s1;

		if (32'(cfg.keep_count) > 32'(MAX_TOP_K)) begin
			k_lim = FILL_W'(MAX_TOP_K);
		end else begin
			k_lim = FILL_W'(cfg.keep_count);
		end
		fill_eff = (filled_q > k_lim) ? k_lim : filled_q;
		in_range = (32'(elem_cnt_q) < 32'(MAX_CLASSES));

		ge_last_slot = 1'b0;
		for (int j = 0; j < MAX_TOP_K; j++) begin
			ge[j] = (32'(j) < 32'(fill_eff)) && (best_score_q[j] >= new_score);
			if (32'(j) + 32'd1 == 32'(k_lim)) ge_last_slot = ge[j];
		end
		for (int j = 0; j < MAX_TOP_K; j++) begin
			lane_wr[j]  = (32'(j) < 32'(k_lim)) && !ge[j];
			lane_new[j] = (j == 0) ? 1'b1 : ge[(j == 0) ? 0 : j-1];
		end
		insert_ok = (k_lim != '0) && ((fill_eff < k_lim) || !ge_last_slot);
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && in_range) begin
			for (int j = 0; j < MAX_TOP_K; j++) begin
				if (lane_wr[j]) begin
					if (lane_new[j]) begin
						best_score_q[j] <= new_score;
						best_idx_q[j]   <= CLASS_W'(elem_cnt_q);
					end else begin
						best_score_q[j] <= best_score_q[(j == 0) ? 0 : j-1];
						best_idx_q[j]   <= best_idx_q[(j == 0) ? 0 : j-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q   <= '0;
			elem_cnt_q <= '0;
			ovf_q      <= 1'b0;
			ptr_q      <= '0;
		end else if (cmd.clear_run) begin
			filled_q   <= '0;
			elem_cnt_q <= '0;
			ovf_q      <= 1'b0;
			ptr_q      <= '0;
		end else if (cmd.insert) begin
			if (in_range) begin
				filled_q   <= (insert_ok && (fill_eff < k_lim)) ? fill_eff + FILL_W'(1) : fill_eff;
				elem_cnt_q <= elem_cnt_q + CNT_W'(1);
			end else begin
				filled_q <= fill_eff;
				ovf_q    <= 1'b1;
			end
		end else if (cmd.emit_adv) begin
			ptr_q <= ptr_q + SLOT_W'(1);
		end
	end

	assign status.last       = last_s1;
	assign status.emit_empty = (filled_q == '0);
	assign status.emit_last  = (FILL_W'(ptr_q) + FILL_W'(1) == filled_q);

	assign class_index    = best_idx_q[ptr_q];
	assign confidence     = best_score_q[ptr_q];
	assign rank           = RANK_W'(ptr_q);
	assign last_result    = status.emit_last;
	assign count_overflow = ovf_q;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for top_k_score_selector: table-driven directed runs, then random runs.
// Compares each result against an in-bench ranking predictor; checks register read-back over APB.
// Depends on tks_pkg, tks_if and the top_k_score_selector RTL.
module tb;
	import tks_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [CLASS_W-1:0]        class_index;
		logic signed [SCORE_W-1:0] confidence;
		logic [RANK_W-1:0]         rank;
		logic                      last_result;
		logic                      count_overflow;
	} result_t;

	typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		reg_idx_t           reg_sel;
		logic [31:0]        data;
		bit                 last;
		bit                 typed;
		int                 typed_n;
		logic [CLASS_W-1:0] idx;
		logic [31:0]        conf;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tks_score_if  score_ch();
	tks_result_if result_ch();

	top_k_score_selector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.scores(score_ch),
		.results(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [KEEP_W-1:0]         cfg_keep;
	bit                        cfg_quant;
	logic [SCORE_W-1:0]        cfg_scale;
	logic [CODE_W-1:0]         cfg_zero;
	logic signed [SCORE_W-1:0] kept_score[MAX_TOP_K];
	logic [CLASS_W-1:0]        kept_index[MAX_TOP_K];
	int                        kept_fill;
	int                        elem_cnt;
	bit                        ovf_seen;

	result_t   pending[$];
	plan_row_t plan[$];

	int  errors;
	int  scores_sent;
	int  results_seen;
	int  runs_done;
	int  reg_writes;
	int  rand_items;
	int  stall_left;
	int  cycle_count;
	bit  calm;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic void flag_error(string msg);
		if (errors < 10)
			$display("mismatch: %s", msg);
		errors++;
	endfunction

	function automatic logic signed [SCORE_W-1:0] dequantize(logic [SCORE_W-1:0] raw);
		longint prod;
		if (!cfg_quant)
			return raw;
		prod = longint'(cfg_scale) * (longint'(raw[7:0]) - longint'(cfg_zero));
		if (prod > longint'(SCORE_MAX))
			return SCORE_MAX;
		if (prod < longint'(SCORE_MIN))
			return SCORE_MIN;
		return prod[31:0];
	endfunction

	function automatic void insert_ranked(logic signed [SCORE_W-1:0] s, logic [CLASS_W-1:0] idx,
		int k);
		int pos = 0;
		int j;
		if (k == 0)
			return;
		while (pos < kept_fill && kept_score[pos] >= s)
			pos++;
		if (pos >= k)
			return;
		j = (kept_fill < k) ? kept_fill : k - 1;
		while (j > pos) begin
			kept_score[j] = kept_score[j-1];
			kept_index[j] = kept_index[j-1];
			j--;
		end
		kept_score[pos] = s;
		kept_index[pos] = idx;
		if (kept_fill < k)
			kept_fill++;
	endfunction

	function automatic int rank_element(logic [SCORE_W-1:0] raw, bit last);
		int k;
		int n;
		logic signed [SCORE_W-1:0] s;
		result_t r;
		k = (cfg_keep > MAX_TOP_K) ? MAX_TOP_K : int'(cfg_keep);
		s = dequantize(raw);
		if (kept_fill > k)
			kept_fill = k;
		if (elem_cnt < MAX_CLASSES) begin
			insert_ranked(s, CLASS_W'(elem_cnt), k);
			elem_cnt++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (!last)
			return 0;
		n = kept_fill;
		for (int i = 0; i < n; i++) begin
			r.class_index    = kept_index[i];
			r.confidence     = kept_score[i];
			r.rank           = RANK_W'(i);
			r.last_result    = (i == n - 1);
			r.count_overflow = ovf_seen;
			pending = {pending, r};
		end
		kept_fill = 0;
		elem_cnt  = 0;
		ovf_seen  = 1'b0;
		runs_done++;
		return n;
	endfunction

	function automatic logic [31:0] reg_mask(reg_idx_t sel);
		case (sel)
			REG_KEEP_COUNT:   return 32'h0000_001F;
			REG_SCORE_FORMAT: return 32'h0000_0001;
			REG_QUANT_SCALE:  return 32'hFFFF_FFFF;
			default:          return 32'h0000_00FF;
		endcase
	endfunction

	function automatic plan_row_t item_row(logic [31:0] data, bit last);
		plan_row_t r;
		r.kind    = ROW_ITEM;
		r.reg_sel = REG_KEEP_COUNT;
		r.data    = data;
		r.last    = last;
		r.typed   = 1'b0;
		r.typed_n = 0;
		r.idx     = '0;
		r.conf    = '0;
		return r;
	endfunction

	function automatic plan_row_t known_row(logic [31:0] data, int n, logic [CLASS_W-1:0] idx,
		logic [31:0] conf);
		plan_row_t r;
		r         = item_row(data, 1'b1);
		r.typed   = 1'b1;
		r.typed_n = n;
		r.idx     = idx;
		r.conf    = conf;
		return r;
	endfunction

	function automatic plan_row_t write_row(reg_idx_t sel, logic [31:0] data);
		plan_row_t r;
		r         = item_row(data, 1'b0);
		r.kind    = ROW_WRITE;
		r.reg_sel = sel;
		return r;
	endfunction

	function automatic void add_row(plan_row_t r);
		plan = {plan, r};
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.class_index    = result_ch.class_index;
			got.confidence     = result_ch.confidence;
			got.rank           = result_ch.rank;
			got.last_result    = result_ch.last_result;
			got.count_overflow = result_ch.count_overflow;
			results_seen++;
			if (pending.size() == 0) begin
				flag_error($sformatf("unexpected result idx=%0d conf=%h rank=%0d last=%b ovf=%b",
					got.class_index, got.confidence, got.rank, got.last_result,
					got.count_overflow));
			end else begin
				want = pending.pop_front();
				if (got.class_index !== want.class_index || got.confidence !== want.confidence ||
					got.rank !== want.rank || got.last_result !== want.last_result ||
					got.count_overflow !== want.count_overflow) begin
					flag_error($sformatf({"expected idx=%0d conf=%h rank=%0d last=%b ovf=%b, ",
						"got idx=%0d conf=%h rank=%0d last=%b ovf=%b"},
						want.class_index, want.confidence, want.rank, want.last_result,
						want.count_overflow, got.class_index, got.confidence, got.rank,
						got.last_result, got.count_overflow));
				end
			end
		end
	end

	task automatic send_score(input logic [31:0] raw, input bit last, output int n_new);
		score_ch.valid        <= 1'b1;
		score_ch.score_value  <= raw;
		score_ch.last_element <= last;
		do
			@(posedge clk);
		while (!score_ch.ready);
		scores_sent++;
		n_new = rank_element(raw, last);
	endtask

	task automatic idle_sender(input int gap);
		if (gap > 0) begin
			score_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		score_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t sel, input logic [31:0] value);
		logic [31:0] val;
		logic [31:0] rd;
		val = value & reg_mask(sel);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({sel, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== val)
			flag_error($sformatf("register %s read back %h, wrote %h", sel.name(), rd, val));
		case (sel)
			REG_KEEP_COUNT:   cfg_keep  = val[KEEP_W-1:0];
			REG_SCORE_FORMAT: cfg_quant = val[0];
			REG_QUANT_SCALE:  cfg_scale = val;
			default:          cfg_zero  = val[CODE_W-1:0];
		endcase
		reg_writes++;
	endtask

	function automatic logic [31:0] pick_keep();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return MAX_TOP_K;
			2:       return 31;
			3:       return MAX_TOP_K + 1;
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic logic [31:0] make_score();
		logic [31:0] r;
		r = $urandom;
		if (cfg_quant) begin
			case ($urandom_range(0, 5))
				0:       return {r[31:8], 8'h00};
				1:       return {r[31:8], 8'hFF};
				2:       return {r[31:8], cfg_zero};
				default: return r;
			endcase
		end
		case ($urandom_range(0, 7))
			0:       return SCORE_MAX;
			1:       return SCORE_MIN;
			2:       return 32'hFFFF_FFFF;
			3, 4:    return 32'($signed($urandom_range(0, 6)) - 3);
			default: return r;
		endcase
	endfunction

	task automatic reconfigure();
		if ($urandom_range(0, 1))
			write_reg(REG_KEEP_COUNT, pick_keep());
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SCORE_FORMAT, $urandom_range(0, 1));
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 4))
				0:       write_reg(REG_QUANT_SCALE, 32'h0);
				1:       write_reg(REG_QUANT_SCALE, 32'hFFFF_FFFF);
				2:       write_reg(REG_QUANT_SCALE, 32'h0001_0000);
				3:       write_reg(REG_QUANT_SCALE, $urandom);
				default: write_reg(REG_QUANT_SCALE, $urandom_range(1, 32'h0003_0000));
			endcase
		end
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 2))
				0:       write_reg(REG_QUANT_ZERO, 32'h0);
				1:       write_reg(REG_QUANT_ZERO, 32'hFF);
				default: write_reg(REG_QUANT_ZERO, $urandom);
			endcase
		end
	endtask

	task automatic random_phase(input int target);
		int goal;
		int len;
		int n_new;
		goal = rand_items + target;
		while (rand_items < goal) begin
			wait_drain();
			reconfigure();
			calm = ($urandom_range(0, 3) == 0);
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				if (i > 0 && $urandom_range(0, 11) == 0) begin
					wait_drain();
					if ($urandom_range(0, 1))
						write_reg(REG_KEEP_COUNT, pick_keep());
				end
				send_score(make_score(), i == len - 1, n_new);
				rand_items++;
				idle_sender(gap_len());
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		int n_new;
		result_t r;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		score_ch.valid        = 1'b0;
		score_ch.score_value  = '0;
		score_ch.last_element = 1'b0;
		result_ch.ready       = 1'b1;
		stall_left            = 0;
		calm                  = 1'b0;
		cfg_keep              = 5'd1;
		cfg_quant             = 1'b0;
		cfg_scale             = 32'h0001_0000;
		cfg_zero              = '0;
		kept_fill             = 0;
		elem_cnt              = 0;
		ovf_seen              = 1'b0;
		foreach (kept_score[i]) begin
			kept_score[i] = '0;
			kept_index[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		add_row(item_row(SCORE_MIN, 1'b0));
		add_row(known_row(SCORE_MAX, 1, CLASS_W'(1), SCORE_MAX));
		add_row(known_row(32'h0, 1, CLASS_W'(0), 32'h0));
		add_row(write_row(REG_KEEP_COUNT, 0));
		add_row(known_row(32'h5, 0, CLASS_W'(0), 32'h0));
		add_row(write_row(REG_KEEP_COUNT, 31));
		add_row(item_row(32'h3, 1'b0));
		add_row(item_row(32'h3, 1'b0));
		add_row(item_row(32'hFFFF_FFFF, 1'b0));
		add_row(item_row(32'h7, 1'b0));
		add_row(item_row(SCORE_MIN, 1'b0));
		add_row(item_row(32'h3, 1'b1));
		add_row(write_row(REG_KEEP_COUNT, 4));
		add_row(item_row(32'd10, 1'b0));
		add_row(item_row(32'd20, 1'b0));
		add_row(item_row(32'd30, 1'b0));
		add_row(item_row(32'd40, 1'b0));
		add_row(write_row(REG_KEEP_COUNT, 2));
		add_row(item_row(32'd5, 1'b1));
		add_row(write_row(REG_KEEP_COUNT, 1));
		add_row(write_row(REG_SCORE_FORMAT, 1));
		add_row(write_row(REG_QUANT_SCALE, 32'hFFFF_FFFF));
		add_row(write_row(REG_QUANT_ZERO, 128));
		add_row(known_row(32'hABCD_EFFF, 1, CLASS_W'(0), SCORE_MAX));
		add_row(known_row(32'hFFFF_FF00, 1, CLASS_W'(0), SCORE_MIN));
		add_row(write_row(REG_QUANT_SCALE, 32'h0));
		add_row(known_row(32'h1234_5677, 1, CLASS_W'(0), 32'h0));
		add_row(write_row(REG_QUANT_SCALE, 32'h0001_0000));
		add_row(write_row(REG_QUANT_ZERO, 255));
		add_row(known_row(32'h0000_0000, 1, CLASS_W'(0), 32'hFF01_0000));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_drain();
				write_reg(plan[i].reg_sel, plan[i].data);
			end else begin
				send_score(plan[i].data, plan[i].last, n_new);
				if (plan[i].typed) begin
					repeat (n_new) void'(pending.pop_back());
					if (plan[i].typed_n == 1) begin
						r.class_index    = plan[i].idx;
						r.confidence     = plan[i].conf;
						r.rank           = '0;
						r.last_result    = 1'b1;
						r.count_overflow = 1'b0;
						pending = {pending, r};
					end
				end
				idle_sender(gap_len());
			end
		end

		random_phase(100);
		random_phase(100);

		wait_drain();
		repeat (8) @(posedge clk);
		$display("covered %0d score transactions over %0d runs, %0d results checked",
			scores_sent, runs_done, results_seen);
		$display("%0d register writes across keep count, score format, scale and zero point",
			reg_writes);
		if (errors == 0 && pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
